/* design/frta_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frta_pkg: shared types and constants of the free range table allocator
// Commands, status codes, controller states and controller-datapath signals.
// ----------------------------------------------------------------------------
package frta_pkg;
    localparam int TableEntriesDef = 16;
    localparam int AddressBitsDef  = 16;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_REM   = 2'd1;
    localparam logic [1:0] CMD_ALLOC = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_EVAL,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_APPEND,
        S_ALLOC_WR,
        S_MOVE_RD,
        S_MOVE_WR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_cur;
        logic rd_next;
        logic rd_last;
        logic eval;
        logic shift_wr;
        logic append;
        logic alloc_wr;
        logic move_wr;
    } t_cmd;

    typedef struct packed {
        logic scan_end;
        logic shift_end;
        logic go_append;
        logic go_shift;
        logic go_alloc;
        logic go_out;
        logic alloc_move;
    } t_stat;
endpackage
`default_nettype wire

/* design/frta_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frta_if: valid/ready channel carrying one item
// Payload width is set by the type parameter.
// ----------------------------------------------------------------------------
interface frta_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/frta_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frta_ctrl: command sequencer
// Steps the datapath through scan, shift, append and allocate phases.
// ----------------------------------------------------------------------------
module frta_ctrl import frta_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_fire,
    input  wire logic  i_out_fire,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_in_ready,
    output logic       o_out_valid
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_fire) n_state = S_RD;
            S_RD: begin
                if (i_stat.scan_end) begin
                    if (i_stat.go_append) n_state = S_APPEND;
                    else if (i_stat.go_alloc) n_state = S_ALLOC_WR;
                    else n_state = S_OUT;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.go_out) n_state = S_OUT;
                else if (i_stat.go_append) n_state = S_APPEND;
                else if (i_stat.go_shift) n_state = S_SHIFT_RD;
                else if (i_stat.go_alloc) n_state = S_ALLOC_WR;
                else n_state = S_RD;
            end
            S_SHIFT_RD: n_state = i_stat.shift_end ? S_RD : S_SHIFT_WR;
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_APPEND: n_state = S_OUT;
            S_ALLOC_WR: n_state = i_stat.alloc_move ? S_MOVE_RD : S_OUT;
            S_MOVE_RD: n_state = S_MOVE_WR;
            S_MOVE_WR: n_state = S_OUT;
            S_OUT: if (i_out_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_fire;
            end
            S_RD: o_cmd.rd_cur = 1'b1;
            S_EVAL: o_cmd.eval = 1'b1;
            S_SHIFT_RD: o_cmd.rd_next = 1'b1;
            S_SHIFT_WR: o_cmd.shift_wr = 1'b1;
            S_APPEND: o_cmd.append = 1'b1;
            S_ALLOC_WR: o_cmd.alloc_wr = 1'b1;
            S_MOVE_RD: o_cmd.rd_last = 1'b1;
            S_MOVE_WR: o_cmd.move_wr = 1'b1;
            S_OUT: o_out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

/* design/frta_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frta_dp: range table datapath
// Holds the range memory, scan index, best-fit tracking and result registers.
// ----------------------------------------------------------------------------
module frta_dp import frta_pkg::*; #(
    parameter int TABLE_ENTRIES = TableEntriesDef,
    parameter int ADDRESS_BITS  = AddressBitsDef
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cmd                    i_cmd,
    input  wire logic [1:0]              i_command,
    input  wire logic [ADDRESS_BITS-1:0] i_start,
    input  wire logic [ADDRESS_BITS-1:0] i_len,
    output t_stat                        o_stat,
    output logic [1:0]                   o_status,
    output logic [ADDRESS_BITS-1:0]      o_granted
);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int AW = ADDRESS_BITS;
    localparam int LW = ADDRESS_BITS + 1;
    localparam int EW = ADDRESS_BITS + 2;

    logic [AW-1:0] r_mem_s [TABLE_ENTRIES];
    logic [LW-1:0] r_mem_l [TABLE_ENTRIES];

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_sidx;
    logic [1:0]    r_op;
    logic [EW-1:0] r_a;
    logic [EW-1:0] r_len;
    logic [AW-1:0] r_rs;
    logic [LW-1:0] r_rl;
    logic          r_found;
    logic [IW-1:0] r_best;
    logic [LW-1:0] r_bl;
    logic [AW-1:0] r_bs;
    logic [1:0]    r_status;
    logic [AW-1:0] r_granted;

    logic [EW-1:0] w_s, w_he, w_e;
    logic          w_scan_end, w_shift_end;
    logic          w_ovl_none, w_split, w_cover, w_tail;
    logic          w_fit, w_exact;
    logic [IW-1:0] w_ii, w_last;
    logic [LW-1:0] w_nl;

    assign w_ii        = r_idx[IW-1:0];
    assign w_last      = r_count[IW-1:0];
    assign w_scan_end  = (r_idx >= r_count);
    assign w_shift_end = (r_sidx + CW'(1) > r_count);
    assign w_s  = EW'(r_rs);
    assign w_he = EW'(r_rs) + EW'(r_rl);
    assign w_e  = r_a + r_len;
    assign w_ovl_none = (r_a >= w_he) || (w_e <= w_s);
    assign w_split = (w_s < r_a) && (w_he > w_e);
    assign w_cover = (r_a <= w_s) && (w_e >= w_he);
    assign w_tail  = (w_s <= r_a) && (w_he <= w_e);
    assign w_fit   = (EW'(r_rl) >= r_len) && (!r_found || r_bl > r_rl);
    assign w_exact = (EW'(r_rl) == r_len);
    assign w_nl    = r_bl - LW'(r_len);

    always_comb begin
        o_stat = '0;
        o_stat.scan_end  = w_scan_end;
        o_stat.shift_end = w_shift_end;
        o_stat.alloc_move = (w_nl == '0);
        if (i_cmd.rd_cur && w_scan_end) begin
            o_stat.go_append = (r_op == CMD_ADD) && (r_len != '0);
            o_stat.go_alloc  = (r_op == CMD_ALLOC) && r_found;
        end
        if (i_cmd.eval) begin
            case (r_op)
                CMD_ADD: begin
                    if (r_a >= w_s && r_a <= w_he) o_stat.go_out = 1'b1;
                end
                CMD_REM: begin
                    if (!w_ovl_none && !w_split && w_cover) o_stat.go_shift = 1'b1;
                end
                CMD_ALLOC: begin
                    if (w_fit && w_exact) o_stat.go_alloc = 1'b1;
                end
                default: o_stat.go_out = 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_status <= ST_DONE;
            r_granted <= '0;
        end else begin
            if (i_cmd.load) begin
                r_status <= (i_len == '0 && i_command == CMD_ALLOC) ? ST_NOFIT : ST_DONE;
                r_granted <= '0;
            end
            if (i_cmd.rd_cur && w_scan_end && r_op == CMD_ALLOC && !r_found
                && r_len != '0) begin
                r_status <= ST_NOFIT;
            end
            if (i_cmd.eval && r_op == CMD_REM && !w_ovl_none && w_cover) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.append) begin
                if (r_count >= CW'(TABLE_ENTRIES)) begin
                    r_status <= ST_FULL;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.alloc_wr) begin
                r_granted <= r_bs;
                if (w_nl == '0) r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_command;
            r_a <= EW'(i_start);
            r_len <= EW'(i_len);
            r_idx <= (i_len == '0) ? CW'(TABLE_ENTRIES) : '0;
            r_found <= 1'b0;
        end
        if (i_cmd.rd_cur && !w_scan_end) begin
            r_rs <= r_mem_s[w_ii];
            r_rl <= r_mem_l[w_ii];
        end
        if (i_cmd.rd_next && !w_shift_end) begin
            r_rs <= r_mem_s[IW'(r_sidx + CW'(1))];
            r_rl <= r_mem_l[IW'(r_sidx + CW'(1))];
        end
        if (i_cmd.rd_last) begin
            r_rs <= r_mem_s[w_last];
            r_rl <= r_mem_l[w_last];
        end
        if (i_cmd.shift_wr) begin
            r_mem_s[r_sidx[IW-1:0]] <= r_rs;
            r_mem_l[r_sidx[IW-1:0]] <= r_rl;
            r_sidx <= r_sidx + CW'(1);
        end
        if (i_cmd.eval) begin
            case (r_op)
                CMD_ADD: begin
                    if (r_a >= w_s && r_a <= w_he) begin
                        if (w_e > w_he) r_mem_l[w_ii] <= LW'(w_e - w_s);
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                CMD_REM: begin
                    if (w_ovl_none) begin
                        r_idx <= r_idx + CW'(1);
                    end else if (w_split) begin
                        r_mem_l[w_ii] <= LW'(r_a - w_s);
                        r_op <= CMD_ADD;
                        r_idx <= '0;
                        r_a <= w_e;
                        r_len <= w_he - w_e;
                    end else if (w_cover) begin
                        r_sidx <= r_idx;
                    end else if (w_tail) begin
                        r_mem_l[w_ii] <= LW'(r_a - w_s);
                        r_idx <= r_idx + CW'(1);
                    end else begin
                        r_mem_s[w_ii] <= AW'(w_e);
                        r_mem_l[w_ii] <= LW'(w_he - w_e);
                        r_idx <= r_idx + CW'(1);
                    end
                end
                CMD_ALLOC: begin
                    r_idx <= r_idx + CW'(1);
                    if (w_fit) begin
                        r_found <= 1'b1;
                        r_best <= w_ii;
                        r_bl <= r_rl;
                        r_bs <= r_rs;
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.append && r_count < CW'(TABLE_ENTRIES)) begin
            r_mem_s[r_count[IW-1:0]] <= AW'(r_a);
            r_mem_l[r_count[IW-1:0]] <= LW'(r_len);
        end
        if (i_cmd.alloc_wr) begin
            r_mem_s[r_best] <= r_bs + AW'(r_len);
            r_mem_l[r_best] <= w_nl;
            r_bl <= w_nl;
        end
        if (i_cmd.move_wr && w_last != r_best) begin
            r_mem_s[r_best] <= r_rs;
            r_mem_l[r_best] <= r_rl;
        end
    end

    assign o_status  = r_status;
    assign o_granted = r_granted;
endmodule
`default_nettype wire

/* design/free_range_table_allocator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// free_range_table_allocator_unit: free range table allocator
// Add, remove and best-fit allocate over a table of free address ranges.
// ----------------------------------------------------------------------------
// Commands scan the table entry by entry, reading then evaluating each;
// a remove that deletes an entry shifts the later entries down one by one,
// and a split rescans as an add.
// The unit takes one command at a time; a new command is accepted only when idle.
// Reset clears the range count; table contents are not cleared.
module free_range_table_allocator_unit import frta_pkg::*; #(
    parameter int TABLE_ENTRIES = TableEntriesDef,
    parameter int ADDRESS_BITS  = AddressBitsDef
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    frta_if.sink     i_cmd_ch,
    frta_if.source   o_res_ch
);
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_fire, w_out_fire, w_out_valid;
    logic [1:0] w_status;
    logic [ADDRESS_BITS-1:0] w_granted;

    assign w_in_fire  = i_cmd_ch.valid && i_cmd_ch.ready;
    assign w_out_fire = o_res_ch.valid && o_res_ch.ready;

    frta_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_in_fire),
        .i_out_fire(w_out_fire), .i_stat(w_stat), .o_cmd(w_cmd),
        .o_in_ready(i_cmd_ch.ready), .o_out_valid(w_out_valid)
    );

    frta_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .ADDRESS_BITS(ADDRESS_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_command(i_cmd_ch.data.command),
        .i_start(ADDRESS_BITS'(i_cmd_ch.data.start_address)),
        .i_len(ADDRESS_BITS'(i_cmd_ch.data.length)),
        .o_stat(w_stat), .o_status(w_status), .o_granted(w_granted)
    );

    assign o_res_ch.valid = w_out_valid;
    assign o_res_ch.data.status = w_status;
    assign o_res_ch.data.granted_address = 16'(w_granted);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd_ch.ready && o_res_ch.valid)) else $error("ready while result pending");
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_ch.valid && !o_res_ch.ready |=> o_res_ch.valid)
        else $error("result dropped");
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_ch.valid && o_res_ch.data.status != ST_DONE |->
        o_res_ch.data.granted_address == '0) else $error("grant on failure");
endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: free range table allocator unit
// Drives add, remove and allocate commands over valid/ready channels, mirrors
// the free range table in a local model and checks every status and grant.
// ----------------------------------------------------------------------------
module testbench;
    import frta_pkg::*;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] start_address;
        logic [15:0] length;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] granted_address;
    } res_item_t;

    localparam int Entries = 16;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic quiet = 1'b0;
    int   mismatches = 0;

    frta_if #(.T(cmd_item_t)) cmd_ch ();
    frta_if #(.T(res_item_t)) res_ch ();

    free_range_table_allocator_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_ch (cmd_ch),
        .o_res_ch (res_ch)
    );

    // free range table mirror
    longint unsigned free_start [Entries];
    longint unsigned free_len   [Entries];
    int unsigned     free_count = 0;
    res_item_t       expected_results [$];

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [1:0] add_free(longint unsigned a, longint unsigned len);
        longint unsigned e;
        longint unsigned he;
        e = a + len;
        if (len == 0) return ST_DONE;
        for (int i = 0; i < free_count; i++) begin
            he = free_start[i] + free_len[i];
            if (a >= free_start[i] && a <= he) begin
                if (e > he) free_len[i] = (e - free_start[i]) & 64'h1ffff;
                return ST_DONE;
            end
        end
        if (free_count >= Entries) return ST_FULL;
        free_start[free_count] = a & 64'hffff;
        free_len[free_count] = len & 64'h1ffff;
        free_count++;
        return ST_DONE;
    endfunction

    function automatic logic [1:0] remove_free(longint unsigned a, longint unsigned len);
        longint unsigned e;
        longint unsigned s;
        longint unsigned he;
        int i;
        e = a + len;
        i = 0;
        if (len == 0) return ST_DONE;
        while (i < free_count) begin
            s = free_start[i];
            he = s + free_len[i];
            if (a >= he || e <= s) begin
                i++;
            end else if (s < a && he > e) begin
                free_len[i] = (a - s) & 64'h1ffff;
                return add_free(e, he - e);
            end else if (a <= s && e >= he) begin
                for (int j = i; j + 1 < free_count; j++) begin
                    free_start[j] = free_start[j + 1];
                    free_len[j] = free_len[j + 1];
                end
                free_count--;
            end else if (s <= a && he <= e) begin
                free_len[i] = (a - s) & 64'h1ffff;
                i++;
            end else begin
                free_start[i] = e & 64'hffff;
                free_len[i] = (he - e) & 64'h1ffff;
                i++;
            end
        end
        return ST_DONE;
    endfunction

    function automatic res_item_t alloc_free(longint unsigned len);
        res_item_t r;
        int best;
        bit found;
        best = 0;
        found = 0;
        r = '{status: ST_NOFIT, granted_address: '0};
        if (len == 0) return r;
        for (int i = 0; i < free_count; i++) begin
            if (free_len[i] >= len && (!found || free_len[best] > free_len[i])) begin
                best = i;
                found = 1;
                if (free_len[i] == len) break;
            end
        end
        if (!found) return r;
        r.status = ST_DONE;
        r.granted_address = free_start[best][15:0];
        free_start[best] = (free_start[best] + len) & 64'hffff;
        free_len[best] = free_len[best] - len;
        if (free_len[best] == 0) begin
            if (free_count - 1 != best) begin
                free_start[best] = free_start[free_count - 1];
                free_len[best] = free_len[free_count - 1];
            end
            free_count--;
        end
        return r;
    endfunction

    function automatic res_item_t predict_result(cmd_item_t it);
        res_item_t r;
        r = '{status: ST_DONE, granted_address: '0};
        case (it.command)
            CMD_ADD:   r.status = add_free(it.start_address, it.length);
            CMD_REM:   r.status = remove_free(it.start_address, it.length);
            CMD_ALLOC: r = alloc_free(it.length);
            default:   r.status = ST_DONE;
        endcase
        return r;
    endfunction

    task automatic send_item(logic [1:0] cmd, int a, int len);
        cmd_item_t it;
        it = '{command: cmd, start_address: a[15:0], length: len[15:0]};
        if (!quiet && $urandom_range(0, 3) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data <= it;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        expected_results.push_back(predict_result(it));
    endtask

    // result checker
    always @(posedge i_clk) begin
        res_item_t want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", res_ch.data);
            end else begin
                want = expected_results.pop_front();
                if (res_ch.data.status !== want.status ||
                    res_ch.data.granted_address !== want.granted_address) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, res_ch.data);
                end
            end
        end
    end

    // result stalls
    initial begin
        res_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    task automatic test_special_cases();
        send_item(CMD_ALLOC, 0, 5);
        send_item(CMD_ADD, 100, 0);
        send_item(CMD_ADD, 100, 50);
        send_item(CMD_ADD, 120, 60);
        send_item(CMD_REM, 110, 0);
        send_item(CMD_ALLOC, 0, 0);
        send_item(CMD_REM, 130, 10);
        send_item(CMD_REM, 90, 20);
        send_item(CMD_REM, 170, 50);
        send_item(CMD_UNKNOWN, 16'hffff, 16'hffff);
        send_item(CMD_ADD, 65535, 10);
        send_item(CMD_ALLOC, 0, 3);
        send_item(CMD_ADD, 65530, 100);
        send_item(CMD_REM, 65000, 600);
        send_item(CMD_ADD, 0, 65535);
        send_item(CMD_ALLOC, 0, 65535);
        send_item(CMD_ALLOC, 0, 40);
        send_item(CMD_ALLOC, 0, 1000);
        send_item(CMD_REM, 0, 65535);
        send_item(CMD_REM, 65535, 65535);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < Entries + 1; i++) send_item(CMD_ADD, i * 1000, 100);
        send_item(CMD_REM, 3020, 10);
        for (int i = 0; i < Entries + 2; i++) send_item(CMD_ALLOC, 0, 90 + i);
    endtask

    task automatic test_random_mix(int count);
        int a;
        int len;
        int pick;
        for (int n = 0; n < count; n++) begin
            if (n == count - 60) quiet = 1'b1;
            pick = $urandom_range(0, 99);
            a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
              : ($urandom_range(0, 9) == 0) ? $urandom_range(65000, 65535)
              : $urandom_range(0, 4095);
            len = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 65535)
                : $urandom_range(0, 300);
            if (pick < 40) send_item(CMD_ADD, a, len);
            else if (pick < 65) send_item(CMD_REM, a, len);
            else if (pick < 97) send_item(CMD_ALLOC, a, len);
            else send_item(CMD_UNKNOWN, a, len);
        end
    endtask

    initial begin
        int waited;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_cases();
        test_full_table();
        test_random_mix(400);
        cmd_ch.valid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

/* sim.f */
design/frta_pkg.sv
design/frta_if.sv
design/frta_ctrl.sv
design/frta_dp.sv
design/free_range_table_allocator_unit.sv
tb/testbench.sv
